// ===== rtl/swlfp_pkg.sv =====
// Shared types and constants for the sync word framed byte parser.
`default_nettype none

package swlfp_pkg;

  // Sync word, sent first byte first
  localparam logic [7:0] SYNC_BYTE0 = 8'h49;
  localparam logic [7:0] SYNC_BYTE1 = 8'h54;
  localparam logic [7:0] SYNC_BYTE2 = 8'h53;
  localparam logic [7:0] SYNC_BYTE3 = 8'h35;

  // Header layout, as stream positions after the start of the sync word
  localparam int TYPE_POS     = 4;
  localparam int SEC_POS      = 5;
  localparam int USEC_POS     = 9;
  localparam int LEN_LOW_POS  = 13;
  localparam int LEN_HIGH_POS = 14;
  localparam int HEADER_BYTES = 15;

  // Default receive buffer size in bytes (header plus payload)
  localparam int BUFFER_BYTES_DEF = 256;

  // One result request
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_done;
    logic [7:0]  frame_type;
    logic [31:0] seconds;
    logic [31:0] microseconds;
    logic [7:0]  payload_len;
  } result_t;

  // Expected byte of the sync word at a given hunt position
  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = SYNC_BYTE0;
      2'd1:    val = SYNC_BYTE1;
      2'd2:    val = SYNC_BYTE2;
      default: val = SYNC_BYTE3;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sync_word_length_frame_parser.sv =====
// Sync word framed byte parser: header capture, payload streaming, output skid stage.
//
// Usage: bytes of a serial stream enter on in_byte, one request per accepted
// in_valid/in_stall handshake. The parser hunts for the four byte sync word,
// captures the 15 byte header (sync, type, seconds, microseconds, length) and
// then streams each payload byte out with its offset. The last payload byte
// carries out_frame_done; an empty payload gives one request with
// out_frame_done set on the high length byte. Sync and header bytes, and
// frames longer than the buffer, give no output request.
// Throughput: one byte per cycle while in_stall is low; the whole decision for
// a byte is one level of logic from the position counter and held header into
// the output register, or into the skid register while the output is stalled.
// Stall: a result caught by out_stall moves into a one entry skid register;
// in_stall is high while that register is occupied, from the cycle after the
// stalled edge up to and including the cycle in which the skid entry moves to
// the output.
// Reset (rst_n low at a clock edge) clears the position counter, the held
// header and both output valid flags; hunting starts on the next byte.
`default_nettype none

module sync_word_length_frame_parser
  import swlfp_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_index,
  output logic             out_frame_done,
  output logic [7:0]       out_frame_type,
  output logic [31:0]      out_seconds,
  output logic [31:0]      out_microseconds,
  output logic [7:0]       out_payload_len
);

  localparam int MAX_LEN = BUFFER_BYTES - HEADER_BYTES;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int POS_W   = $clog2(BUFFER_BYTES);

  localparam logic [POS_W-1:0] P_TYPE  = POS_W'(TYPE_POS);
  localparam logic [POS_W-1:0] P_SEC   = POS_W'(SEC_POS);
  localparam logic [POS_W-1:0] P_USEC  = POS_W'(USEC_POS);
  localparam logic [POS_W-1:0] P_LLOW  = POS_W'(LEN_LOW_POS);
  localparam logic [POS_W-1:0] P_LHIGH = POS_W'(LEN_HIGH_POS);
  localparam logic [POS_W-1:0] P_HDR   = POS_W'(HEADER_BYTES);
  localparam logic [16:0]      MAX_LEN_V = 17'(MAX_LEN);

  // Parser state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [31:0]      sec_r, sec_nxt;
  logic [31:0]      usec_r, usec_nxt;
  logic [7:0]       len_low_r, len_low_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // Output and skid registers
  result_t out_r, out_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t skid_r, skid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  result_t res;
  logic    res_valid;
  logic    accept;
  logic [15:0]      len_full;
  logic [POS_W:0]   pos_inc;
  logic [POS_W:0]   frame_end;
  logic [POS_W-1:0] pay_idx;
  logic [1:0]       lane;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign len_full  = {in_byte, len_low_r};
  assign pos_inc   = {1'b0, pos_r} + (POS_W+1)'(1);
  assign frame_end = (POS_W+1)'(HEADER_BYTES) + (POS_W+1)'(len_r);
  assign pay_idx   = pos_r - P_HDR;

  // Byte decode: next position, header capture and result for this byte
  always_comb begin
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    sec_nxt     = sec_r;
    usec_nxt    = usec_r;
    len_low_nxt = len_low_r;
    len_nxt     = len_r;
    res_valid   = 1'b0;
    res.payload_valid = 1'b0;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    res.frame_done    = 1'b0;
    lane = 2'd0;

    if (pos_r < P_TYPE) begin
      // sync hunt; a mismatch retests the byte as the first sync byte
      if (in_byte == sync_byte(pos_r[1:0])) begin
        pos_nxt = pos_inc[POS_W-1:0];
      end else begin
        pos_nxt = (in_byte == SYNC_BYTE0) ? POS_W'(1) : '0;
      end
    end else if (pos_r == P_TYPE) begin
      type_nxt = in_byte;
      pos_nxt  = pos_inc[POS_W-1:0];
    end else if (pos_r < P_USEC) begin
      lane = 2'(pos_r - P_SEC);
      sec_nxt[lane*8 +: 8] = in_byte;
      pos_nxt = pos_inc[POS_W-1:0];
    end else if (pos_r < P_LLOW) begin
      lane = 2'(pos_r - P_USEC);
      usec_nxt[lane*8 +: 8] = in_byte;
      pos_nxt = pos_inc[POS_W-1:0];
    end else if (pos_r == P_LLOW) begin
      len_low_nxt = in_byte;
      pos_nxt     = P_LHIGH;
    end else if (pos_r == P_LHIGH) begin
      if ({1'b0, len_full} > MAX_LEN_V) begin
        // oversized frame: drop it and retest this byte
        pos_nxt = (in_byte == SYNC_BYTE0) ? POS_W'(1) : '0;
      end else begin
        len_nxt = LEN_W'(len_full);
        if (len_full == 16'd0) begin
          pos_nxt        = '0;
          res_valid      = 1'b1;
          res.frame_done = 1'b1;
        end else begin
          pos_nxt = P_HDR;
        end
      end
    end else begin
      // payload byte
      res_valid         = 1'b1;
      res.payload_valid = 1'b1;
      res.payload_byte  = in_byte;
      res.payload_index = 8'(pay_idx);
      if (pos_inc >= frame_end) begin
        res.frame_done = 1'b1;
        pos_nxt        = '0;
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
    end

    res.frame_type   = type_nxt;
    res.seconds      = sec_nxt;
    res.microseconds = usec_nxt;
    res.payload_len  = 8'(len_nxt);
  end

  // Output register with one entry skid stage
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      type_r       <= '0;
      sec_r        <= '0;
      usec_r       <= '0;
      len_low_r    <= '0;
      len_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r     <= pos_nxt;
        type_r    <= type_nxt;
        sec_r     <= sec_nxt;
        usec_r    <= usec_nxt;
        len_low_r <= len_low_nxt;
        len_r     <= len_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = out_r.payload_valid;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_index = out_r.payload_index;
  assign out_frame_done    = out_r.frame_done;
  assign out_frame_type    = out_r.frame_type;
  assign out_seconds       = out_r.seconds;
  assign out_microseconds  = out_r.microseconds;
  assign out_payload_len   = out_r.payload_len;

  // Skid entry only ever sits behind a held output request
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register occupied with empty output register");

  // A request without a payload byte is always the end of an empty frame
  a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_payload_valid |-> out_frame_done && out_payload_len == 8'd0)
    else $error("non-payload request that does not close an empty frame");

  // The closing payload byte sits at the last offset of the frame
  a_done_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_payload_valid && out_frame_done && (LEN_W <= 8)
      |-> out_payload_index + 8'd1 == out_payload_len)
    else $error("frame closed at wrong payload offset");

  // A full skid stage blocks input until it drains
  a_stall_holds_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_stall |=> skid_valid_r)
    else $error("skid entry lost while output stalled");

endmodule

`default_nettype wire
